[hw/rtl/prpa_pkg.sv]
// ----------------------------------------------------------------------------
// prpa_pkg
// Shared types and constants of the push-style PageRank accumulator.
// ----------------------------------------------------------------------------
package prpa_pkg;

	// storage sizes
	localparam int LOCAL_NODES  = 1024;
	localparam int SOURCE_NODES = 4096;
	localparam int EDGE_SLOTS   = 16384;
	localparam int LN_W  = $clog2(LOCAL_NODES);
	localparam int SRC_W = $clog2(SOURCE_NODES);
	localparam int ES_W  = $clog2(EDGE_SLOTS);
	localparam int PTR_W = ES_W + 1;

	// request codes
	localparam logic [1:0] REQ_LOAD_BOUND = 2'd0;
	localparam logic [1:0] REQ_LOAD_EDGE  = 2'd1;
	localparam logic [1:0] REQ_CONTRIBUTE = 2'd2;
	localparam logic [1:0] REQ_FINALIZE   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SOURCE = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;
	localparam logic [1:0] ST_SAT       = 2'd3;

	// register byte addresses
	localparam logic [3:0] ADDR_MIN_NODE   = 4'h0;
	localparam logic [3:0] ADDR_DAMPING    = 4'h4;
	localparam logic [3:0] ADDR_BASE_SCORE = 4'h8;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] source_node;
		logic [14:0] edge_start;
		logic [14:0] edge_end;
		logic [13:0] edge_slot;
		logic [31:0] target_node;
		logic [31:0] importance;
		logic [9:0]  local_node;
	} req_t;

	typedef struct packed {
		logic [31:0] new_score;
		logic [1:0]  status;
	} res_t;

	// bound table entry
	typedef struct packed {
		logic        valid;
		logic [14:0] start;
		logic [14:0] stop;
	} bound_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_BOUND,
		S_WALK,
		S_FIN1,
		S_FIN2
	} state_t;

endpackage

[hw/rtl/pagerank_push_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// pagerank_push_accumulator_unit
// One partition's push-style PageRank scatter/accumulate engine.
// ----------------------------------------------------------------------------
// Usage: a request word is taken on the clock edge where start is high and
// busy is low. Every request gives one result word on res, marked by done
// for exactly one cycle; the receiver cannot stall it.
// Load bound and load edge write their table when taken: done follows
// the next cycle and busy stays low, so loads can stream one per cycle.
// Contribute reads the bound table, then walks the source's edges through a
// three-stage pipe (edge read, accumulator read, add and write back) issuing
// one edge per cycle, with forwarding of the last write.
// Finalize runs an accumulator read, a 32x17 multiply, then round and add.
// After reset a sweep over all 4096 bound entries zeroes the bound valid bits
// and the accumulators; busy is high meanwhile. Registers on the APB port
// may be written at any time the block is idle, also during the sweep.
// ----------------------------------------------------------------------------
module pagerank_push_accumulator_unit
	import prpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output res_t        res
);

	// configuration registers
	logic [31:0] min_node_q;
	logic [15:0] damping_q;
	logic [31:0] base_score_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_node_q   <= '0;
			damping_q    <= 16'd9830;
			base_score_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				ADDR_MIN_NODE:   min_node_q   <= pwdata;
				ADDR_DAMPING:    damping_q    <= pwdata[15:0];
				ADDR_BASE_SCORE: base_score_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_MIN_NODE:   prdata = min_node_q;
			ADDR_DAMPING:    prdata = {16'd0, damping_q};
			ADDR_BASE_SCORE: prdata = base_score_q;
			default:         prdata = '0;
		endcase
	end

	// memories
	bound_t      bound_mem [SOURCE_NODES];
	logic [31:0] edge_mem  [EDGE_SLOTS];
	logic [31:0] acc_mem   [LOCAL_NODES];

	bound_t      bound_dout;
	logic [31:0] edge_dout;
	logic [31:0] acc_dout;

	logic             bound_we;
	logic [SRC_W-1:0] bound_waddr;
	bound_t           bound_wdata;
	logic             edge_we;
	logic             acc_we;
	logic [LN_W-1:0]  acc_waddr;
	logic [31:0]      acc_wdata;
	logic [LN_W-1:0]  acc_raddr;

	// control and datapath registers
	state_t           state_q, state_d;
	logic [SRC_W-1:0] clr_q;
	logic [PTR_W-1:0] ptr_q, end_q;
	logic [31:0]      imp_q;
	logic [LN_W-1:0]  lnode_q;
	logic             miss_q, sat_q;
	logic             s1_valid_s1;
	logic             s2_valid_s2;
	logic [LN_W-1:0]  idx_s2;
	logic             fwd_valid_q;
	logic [LN_W-1:0]  fwd_idx_q;
	logic [31:0]      fwd_data_q;
	logic [48:0]      prod_s1;
	logic             done_q;
	res_t             res_q;

	logic accept;
	logic issue;
	logic [31:0] diff;
	logic        is_local;
	logic [31:0] acc_op;
	logic [32:0] acc_sum;
	logic [31:0] acc_new;
	logic        acc_clip;
	logic [48:0] rnd;
	logic [32:0] fin_sum;
	logic [PTR_W-1:0] bound_stop;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign res    = res_q;

	// walk arithmetic
	assign issue    = (state_q == S_WALK) && (ptr_q < end_q);
	assign diff     = edge_dout - min_node_q;
	assign is_local = (diff < 32'(LOCAL_NODES));
	assign acc_op   = (fwd_valid_q && fwd_idx_q == idx_s2) ? fwd_data_q : acc_dout;
	assign acc_sum  = {1'b0, acc_op} + {1'b0, imp_q};
	assign acc_clip = acc_sum[32];
	assign acc_new  = acc_clip ? 32'hFFFF_FFFF : acc_sum[31:0];

	// finalize arithmetic: round half up, then add base score
	assign rnd     = prod_s1 + 49'd32768;
	assign fin_sum = {1'b0, rnd[47:16]} + {1'b0, base_score_q};

	// clamp end of range to the edge list
	assign bound_stop = (PTR_W'(bound_dout.stop) > PTR_W'(EDGE_SLOTS)) ?
		PTR_W'(EDGE_SLOTS) : PTR_W'(bound_dout.stop);

	// next state and memory controls
	always_comb begin
		state_d     = state_q;
		bound_we    = 1'b0;
		bound_waddr = req.source_node;
		bound_wdata = '{valid: 1'b1, start: req.edge_start, stop: req.edge_end};
		edge_we     = 1'b0;
		acc_we      = 1'b0;
		acc_waddr   = idx_s2;
		acc_wdata   = acc_new;
		acc_raddr   = (state_q == S_IDLE) ? req.local_node : diff[LN_W-1:0];
		case (state_q)
			S_CLEAR: begin
				bound_we    = 1'b1;
				bound_waddr = clr_q;
				bound_wdata = '0;
				if (clr_q < SRC_W'(LOCAL_NODES)) begin
					acc_we    = 1'b1;
					acc_waddr = clr_q[LN_W-1:0];
					acc_wdata = '0;
				end
				if (clr_q == SRC_W'(SOURCE_NODES - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_LOAD_BOUND: bound_we = 1'b1;
						REQ_LOAD_EDGE:  edge_we  = 1'b1;
						REQ_CONTRIBUTE: state_d  = S_BOUND;
						default:        state_d  = S_FIN1;
					endcase
				end
			end
			S_BOUND: begin
				state_d = bound_dout.valid ? S_WALK : S_IDLE;
			end
			S_WALK: begin
				acc_we = s2_valid_s2;
				if (!issue && !s1_valid_s1 && !s2_valid_s2)
					state_d = S_IDLE;
			end
			S_FIN1: begin
				acc_we    = 1'b1;
				acc_waddr = lnode_q;
				acc_wdata = '0;
				state_d   = S_FIN2;
			end
			S_FIN2: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (bound_we)
			bound_mem[bound_waddr] <= bound_wdata;
		bound_dout <= bound_mem[req.source_node];
	end

	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[req.edge_slot] <= req.target_node;
		edge_dout <= edge_mem[ptr_q[ES_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[acc_waddr] <= acc_wdata;
		acc_dout <= acc_mem[acc_raddr];
	end

	// state register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
			fwd_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_q + 1'b1;
			s1_valid_s1 <= issue;
			s2_valid_s2 <= s1_valid_s1 && is_local;
			fwd_valid_q <= acc_we && (state_q == S_WALK);
			done_q      <= (accept && (req.req_type == REQ_LOAD_BOUND
				|| req.req_type == REQ_LOAD_EDGE))
				|| (state_q == S_BOUND && !bound_dout.valid)
				|| (state_q == S_WALK && state_d == S_IDLE)
				|| (state_q == S_FIN2);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			imp_q   <= req.importance;
			lnode_q <= req.local_node;
			miss_q  <= 1'b0;
			sat_q   <= 1'b0;
		end
		if (state_q == S_BOUND) begin
			ptr_q <= PTR_W'(bound_dout.start);
			end_q <= bound_stop;
		end else if (issue) begin
			ptr_q <= ptr_q + 1'b1;
		end
		// stage 1: edge target arrives
		idx_s2 <= diff[LN_W-1:0];
		if (s1_valid_s1 && !is_local)
			miss_q <= 1'b1;
		// stage 2: accumulate and remember the write
		fwd_idx_q  <= idx_s2;
		fwd_data_q <= acc_new;
		if (state_q == S_WALK && s2_valid_s2 && acc_clip)
			sat_q <= 1'b1;
		// finalize multiply
		prod_s1 <= acc_dout * (17'h10000 - {1'b0, damping_q});
		// result word
		case (state_q)
			S_BOUND: begin
				res_q.new_score <= '0;
				res_q.status    <= bound_dout.valid ? ST_OK : ST_NO_SOURCE;
			end
			S_WALK: begin
				res_q.new_score <= '0;
				res_q.status    <= miss_q ? ST_RANGE : (sat_q ? ST_SAT : ST_OK);
			end
			S_FIN2: begin
				res_q.new_score <= fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];
				res_q.status    <= fin_sum[32] ? ST_SAT : ST_OK;
			end
			default: begin
				res_q.new_score <= '0;
				res_q.status    <= ST_OK;
			end
		endcase
	end

endmodule

[tb/pagerank_push_accumulator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pagerank_push_accumulator_unit_tb
// Self-checking bench for the push-style PageRank accumulator. It loads bound
// and edge tables, pushes contributions and finalizes nodes. A local model of
// the tables, accumulators and registers predicts each result word, and a
// checker compares the words the block returns against that prediction.
// ----------------------------------------------------------------------------
module pagerank_push_accumulator_unit_tb;
	import prpa_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	res_t        res;

	// local copy of block state
	bit          src_loaded [SOURCE_NODES];
	bit [14:0]   src_first  [SOURCE_NODES];
	bit [14:0]   src_last   [SOURCE_NODES];
	bit [31:0]   slot_target[EDGE_SLOTS];
	bit          slot_set   [EDGE_SLOTS];
	bit [31:0]   node_acc   [LOCAL_NODES];
	bit [31:0]   cfg_min_node;
	bit [15:0]   cfg_damping;
	bit [31:0]   cfg_base_score;

	res_t        score_queue[$];
	int          fail_count;
	int          words_checked;
	int          idle_cycles;
	int          items_sent;
	int          burst_left;

	pagerank_push_accumulator_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.res     (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predicted result word for one request, updating local state
	function automatic res_t predict_push(req_t r);
		res_t       o;
		bit         miss;
		bit         clip;
		bit [31:0]  idx;
		bit [32:0]  sum;
		bit [63:0]  scaled;
		int         s;
		int         e;
		o = '0;
		miss = 0;
		clip = 0;
		case (r.req_type)
			REQ_LOAD_BOUND: begin
				src_loaded[r.source_node] = 1;
				src_first[r.source_node] = r.edge_start;
				src_last[r.source_node] = r.edge_end;
			end
			REQ_LOAD_EDGE: begin
				slot_target[r.edge_slot] = r.target_node;
				slot_set[r.edge_slot] = 1;
			end
			REQ_CONTRIBUTE: begin
				if (!src_loaded[r.source_node]) begin
					o.status = ST_NO_SOURCE;
				end else begin
					s = src_first[r.source_node];
					e = src_last[r.source_node];
					if (e > EDGE_SLOTS)
						e = EDGE_SLOTS;
					for (; s < e; s++) begin
						idx = slot_target[s] - cfg_min_node;
						if (idx < LOCAL_NODES) begin
							sum = node_acc[idx] + r.importance;
							if (sum[32]) begin
								clip = 1;
								node_acc[idx] = '1;
							end else begin
								node_acc[idx] = sum[31:0];
							end
						end else begin
							miss = 1;
						end
					end
					o.status = miss ? ST_RANGE : (clip ? ST_SAT : ST_OK);
				end
			end
			default: begin
				scaled = (64'(node_acc[r.local_node]) * (64'd65536 - cfg_damping)
					+ 64'd32768) >> 16;
				sum = scaled[31:0] + cfg_base_score;
				node_acc[r.local_node] = '0;
				o.new_score = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				o.status = sum[32] ? ST_SAT : ST_OK;
			end
		endcase
		return o;
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
			if (done) begin
				if (score_queue.size() == 0) begin
					$error("unexpected result word: new_score %h status %0d",
						res.new_score, res.status);
					fail_count++;
				end else begin
					want = score_queue.pop_front();
					words_checked++;
					if (res.new_score !== want.new_score) begin
						$error("new_score: expected %h actual %h", want.new_score,
							res.new_score);
						fail_count++;
					end
					if (res.status !== want.status) begin
						$error("status: expected %0d actual %0d", want.status, res.status);
						fail_count++;
					end
				end
			end
		end
	end

	// APB register write, setup then access
	task automatic write_reg(logic [3:0] addr, logic [31:0] data);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = data;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		case (addr)
			ADDR_MIN_NODE:   cfg_min_node = data;
			ADDR_DAMPING:    cfg_damping = data[15:0];
			default:         cfg_base_score = data;
		endcase
	endtask

	// send one request word, with bursty gaps
	task automatic send_word(req_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		burst_left--;
		start = 1;
		req = r;
		@(posedge clk);
		while (busy) @(posedge clk);
		score_queue.push_back(predict_push(r));
		items_sent++;
		@(negedge clk);
		start = 0;
		req = req_t'($urandom());
	endtask

	// wait until all results are in, then let the pipe drain
	task automatic wait_drain();
		while (score_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic req_t make_req(logic [1:0] kind);
		req_t r;
		r = req_t'({$urandom(), $urandom(), $urandom(), $urandom()});
		r.req_type = kind;
		return r;
	endfunction

	task automatic send_bound(int src, int first, int last);
		req_t r;
		r = make_req(REQ_LOAD_BOUND);
		r.source_node = src; r.edge_start = first; r.edge_end = last;
		send_word(r);
	endtask

	task automatic send_edge(int slot, logic [31:0] tgt);
		req_t r;
		r = make_req(REQ_LOAD_EDGE);
		r.edge_slot = slot; r.target_node = tgt;
		send_word(r);
	endtask

	task automatic send_contrib(int src, logic [31:0] imp);
		req_t r;
		r = make_req(REQ_CONTRIBUTE);
		r.source_node = src; r.importance = imp;
		send_word(r);
	endtask

	task automatic send_final(int node);
		req_t r;
		r = make_req(REQ_FINALIZE);
		r.local_node = node;
		send_word(r);
	endtask

	// directed corner cases
	task automatic test_directed();
		write_reg(ADDR_MIN_NODE, 32'd100);
		send_contrib(4095, 32'h1);                 // source never loaded
		send_edge(0, 32'd100);                     // local node 0
		send_edge(1, 32'd1123);                    // local node 1023
		send_edge(2, 32'd99);                      // below range, wraps
		send_edge(16383, 32'd1124);                // above range
		send_edge(3, 32'd101);
		send_bound(0, 0, 2);
		send_contrib(0, 32'hFFFF_FFFF);
		send_contrib(0, 32'h1);                    // accumulator clips
		send_bound(1, 0, 3);
		send_contrib(1, 32'h4000_0000);            // target out of range
		send_bound(2, 5, 5);                       // empty range
		send_contrib(2, 32'h1234);
		send_bound(3, 9, 4);                       // reversed range
		send_contrib(3, 32'h1234);
		send_bound(4095, 16383, 16384);            // ends at list end
		send_contrib(4095, 32'h10);
		send_bound(5, 3, 4);
		send_contrib(5, 32'h2000_0000);
		send_final(0);
		send_final(1023);
		send_final(1);
		send_final(0);                              // cleared node
		wait_drain();
	endtask

	// finalize at each damping and base score extreme
	task automatic test_registers();
		write_reg(ADDR_DAMPING, 32'd0);
		write_reg(ADDR_BASE_SCORE, 32'hFFFF_FFFF);
		send_contrib(0, 32'h8000_0000);
		send_final(0);                             // saturated sum
		send_final(2);
		wait_drain();
		write_reg(ADDR_DAMPING, 32'd65535);
		write_reg(ADDR_BASE_SCORE, 32'd0);
		send_contrib(0, 32'hFFFF_FFFF);
		send_final(0);
		send_final(1023);
		wait_drain();
		write_reg(ADDR_MIN_NODE, 32'hFFFF_FF00);   // range wraps past zero
		send_edge(10, 32'h0000_0010);
		send_edge(11, 32'hFFFF_FF00);
		send_bound(6, 10, 12);
		send_contrib(6, 32'h55);
		send_final(16 + 256);
		send_final(0);
		wait_drain();
	endtask

	// random graphs with small degree, several register settings
	task automatic test_random(int count, logic [31:0] base_id);
		int     kind;
		int     src;
		int     slot;
		int     first;
		req_t   r;
		write_reg(ADDR_MIN_NODE, base_id);
		write_reg(ADDR_DAMPING, $urandom_range(0, 65535));
		write_reg(ADDR_BASE_SCORE, $urandom_range(0, 3) == 0 ? $urandom() :
			$urandom_range(0, 32'h0010_0000));
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				slot = $urandom_range(0, 1) ? $urandom_range(0, 63) :
					$urandom_range(0, EDGE_SLOTS - 1);
				send_edge(slot, $urandom_range(0, 7) == 0 ? $urandom() :
					base_id + $urandom_range(0, LOCAL_NODES - 1));
			end else if (kind < 4) begin
				// bound only over slots already written; some ranges empty or reversed
				first = $urandom_range(0, 60);
				for (int k = first; k < first + 12; k++)
					if (!slot_set[k]) send_edge(k, base_id + $urandom_range(0, 1023));
				src = $urandom_range(0, 1) ? $urandom_range(0, 31) :
					$urandom_range(0, SOURCE_NODES - 1);
				send_bound(src, first, ($urandom_range(0, 15) == 0) ?
					first - $urandom_range(0, first) : first + $urandom_range(0, 12));
			end else if (kind < 8) begin
				r = make_req(REQ_CONTRIBUTE);
				r.source_node = $urandom_range(0, 3) ? $urandom_range(0, 31) : r.source_node;
				if ($urandom_range(0, 3) != 0)
					r.importance = r.importance >> $urandom_range(4, 31);
				if (src_loaded[r.source_node]) begin
					for (int k = src_first[r.source_node]; k < src_last[r.source_node]
						&& k < EDGE_SLOTS; k++)
						if (!slot_set[k]) send_edge(k, base_id);
				end
				send_word(r);
			end else begin
				send_final($urandom_range(0, 1) ? $urandom_range(0, 1023) :
					(slot_target[$urandom_range(0, 63)] - base_id) & 10'h3FF);
			end
		end
		wait_drain();
	endtask

	initial begin
		int base_id;
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		start = 0; req = '0;
		fail_count = 0; words_checked = 0; idle_cycles = 0; items_sent = 0;
		burst_left = 0;
		cfg_min_node = 0; cfg_damping = 16'd9830; cfg_base_score = 0;
		foreach (src_loaded[i]) src_loaded[i] = 0;
		foreach (slot_set[i]) slot_set[i] = 0;
		foreach (node_acc[i]) node_acc[i] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_registers();
		for (int p = 0; p < 4; p++) begin
			base_id = (p == 3) ? 32'hFFFF_FE00 : $urandom_range(0, 5000);
			test_random(110, base_id);
		end
		$display("Covered %0d request words, %0d results checked, over several",
			items_sent, words_checked);
		$display("min_node, damping and base_score settings including extremes.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
